FILE: src/sampled_curve_lerp_macros.svh
// ---------------------------------------------------------------------------
// sampled curve lerp assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ---------------------------------------------------------------------------
`ifndef SAMPLED_CURVE_LERP_MACROS_SVH
`define SAMPLED_CURVE_LERP_MACROS_SVH

// same-cycle implication
`define SCL_ASSERT_IMP(name, clk, rst_n, ant, con, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication
`define SCL_ASSERT_NXT(name, clk, rst_n, ant, con, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

FILE: src/scl_pkg.sv
// ---------------------------------------------------------------------------
// scl_pkg
// shared codes and types of the sampled curve interpolator
// ---------------------------------------------------------------------------
package scl_pkg;

    localparam logic [1:0] CFG_MIN_X        = 2'd0;
    localparam logic [1:0] CFG_SCALE        = 2'd1;
    localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam int IDX_W_MAX  = 16;
    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic                 is_eval;
        logic                 neg;
        logic [63:0]          prod;
        logic [IDX_W_MAX-1:0] wr_index;
        logic [31:0]          wr_data;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

endpackage

FILE: src/scl_front.sv
// ---------------------------------------------------------------------------
// scl_front
// accepts items, drops the ones without effect, forms |x - min_x| * scale
// ---------------------------------------------------------------------------
module scl_front #(
    parameter int SAMPLES = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_cmd,
    input  logic [9:0]     i_sample_index,
    input  logic [31:0]    i_sample_value,
    input  logic [31:0]    i_x,
    input  logic [31:0]    i_min_x,
    input  logic [31:0]    i_scale,
    input  logic [10:0]    i_count,
    input  logic           i_hold,
    output logic           o_busy,
    output logic           o_push,
    output scl_pkg::t_item o_item
);
    import scl_pkg::*;

    localparam logic [31:0] SAMPLES_L = 32'(SAMPLES);

    logic [32:0] d_pos;
    logic [32:0] d_neg;
    logic        neg;
    logic [31:0] mag;
    logic        is_eval;
    logic        keep;
    logic        stall;
    logic [63:0] prod;

    logic                 r_s1_valid;
    logic                 r_s1_is_eval;
    logic                 r_s1_neg;
    logic [31:0]          r_s1_mag;
    logic [IDX_W_MAX-1:0] r_s1_index;
    logic [31:0]          r_s1_data;
    logic                 r_s2_valid;
    t_item                r_s2_item;

    always_comb begin
        d_pos   = {i_x[31], i_x} - {i_min_x[31], i_min_x};
        d_neg   = {i_min_x[31], i_min_x} - {i_x[31], i_x};
        neg     = d_pos[32];
        mag     = neg ? d_neg[31:0] : d_pos[31:0];
        is_eval = (i_cmd == CMD_EVAL);
        keep    = is_eval ? (i_count != 11'd0) : ({22'b0, i_sample_index} < SAMPLES_L);
    end

    assign prod   = r_s1_mag * i_scale;
    assign stall  = r_s2_valid && i_hold;
    assign o_busy = stall;
    assign o_push = r_s2_valid && !i_hold;
    assign o_item = r_s2_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (!stall) begin
            r_s1_valid <= i_accept && keep;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_s1_is_eval       <= is_eval;
            r_s1_neg           <= neg;
            r_s1_mag           <= mag;
            r_s1_index         <= IDX_W_MAX'(i_sample_index);
            r_s1_data          <= i_sample_value;
            r_s2_item.is_eval  <= r_s1_is_eval;
            r_s2_item.neg      <= r_s1_neg;
            r_s2_item.prod     <= prod;
            r_s2_item.wr_index <= r_s1_index;
            r_s2_item.wr_data  <= r_s1_data;
        end
    end

endmodule

FILE: src/scl_fifo.sv
// ---------------------------------------------------------------------------
// scl_fifo
// short item queue between the front and back parts
// ---------------------------------------------------------------------------
module scl_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  scl_pkg::t_item     i_item,
    input  logic               i_pop,
    output scl_pkg::t_item     o_item,
    output scl_pkg::t_fifo_stat o_stat
);
    import scl_pkg::*;

    `include "sampled_curve_lerp_macros.svh"

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);

    t_item            r_entry [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

    assign o_item       = r_entry[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == DEPTH_C);

    `SCL_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push && (r_count == DEPTH_C), i_pop, "item pushed into full queue")
    `SCL_ASSERT_NXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == CNT_W'($past(r_count) + 1'b1), "queue fill count lost an item")

endmodule

FILE: src/scl_back.sv
// ---------------------------------------------------------------------------
// scl_back
// sample table, segment selection and interpolation pipeline
// ---------------------------------------------------------------------------
module scl_back #(
    parameter int SAMPLES   = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scl_pkg::t_item      i_item,
    input  scl_pkg::t_fifo_stat i_stat,
    input  logic [10:0]         i_count,
    output logic                o_pop,
    output logic                o_valid,
    output logic [31:0]         o_value
);
    import scl_pkg::*;

    `include "sampled_curve_lerp_macros.svh"

    localparam int IW   = $clog2(SAMPLES);
    localparam int PW   = 32 + FRAC_BITS;
    localparam int LOW  = PW / 2;
    localparam int HIGH = PW - LOW;

    logic [31:0]   r_mem [SAMPLES];

    logic [63:0]   lower_raw;
    logic [63:0]   t64;
    logic [PW-1:0] tw;
    logic [10:0]   cm1;
    logic          clamp;
    logic [10:0]   lower;
    logic [10:0]   upper;
    logic [31:0]   lower32;
    logic [31:0]   upper32;
    logic [PW-1:0] frac;
    logic          wr_en;

    logic signed [33+LOW:0] mlo_full;
    logic [2*HIGH-1:0]      mhi_full;
    logic [PW-1:0]          sum;

    logic                r_a_valid;
    logic [PW-1:0]       r_a_frac;
    logic [31:0]         r_s0;
    logic [31:0]         r_s1;
    logic                r_b_valid;
    logic signed [32:0]  r_b_diff;
    logic [31:0]         r_b_s0;
    logic [PW-1:0]       r_b_frac;
    logic                r_c_valid;
    logic [PW-1:0]       r_c_mlo;
    logic [HIGH-1:0]     r_c_mhi;
    logic [31:0]         r_c_s0;
    logic                r_d_valid;
    logic [31:0]         r_d_value;

    assign o_pop = !i_stat.empty;
    assign wr_en = o_pop && !i_item.is_eval;

    always_comb begin
        lower_raw = i_item.prod >> (2 * FRAC_BITS);
        t64       = i_item.prod >> FRAC_BITS;
        tw        = t64[PW-1:0];
        cm1       = i_count - 11'd1;
        clamp     = lower_raw > {53'b0, cm1};
        if (i_item.neg) begin
            lower = 11'd0;
        end else if (clamp) begin
            lower = cm1;
        end else begin
            lower = lower_raw[10:0];
        end
        upper   = (lower == cm1) ? cm1 : lower + 11'd1;
        lower32 = 32'(lower);
        upper32 = 32'(upper);
        if (i_item.neg) begin
            frac = PW'(0) - tw;
        end else if (clamp) begin
            frac = tw - (PW'(cm1) << FRAC_BITS);
        end else begin
            frac = PW'(t64[FRAC_BITS-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_item.wr_index[IW-1:0]] <= i_item.wr_data;
        end
        r_s0 <= r_mem[lower32[IW-1:0]];
        r_s1 <= r_mem[upper32[IW-1:0]];
    end

    assign mlo_full = r_b_diff * $signed({1'b0, r_b_frac[LOW-1:0]});
    assign mhi_full = r_b_diff[HIGH-1:0] * r_b_frac[PW-1:LOW];
    assign sum      = r_c_mlo + {r_c_mhi, {LOW{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_a_valid <= o_pop && i_item.is_eval;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_frac  <= frac;
        r_b_diff  <= $signed({r_s1[31], r_s1}) - $signed({r_s0[31], r_s0});
        r_b_s0    <= r_s0;
        r_b_frac  <= r_a_frac;
        r_c_mlo   <= mlo_full[PW-1:0];
        r_c_mhi   <= mhi_full[HIGH-1:0];
        r_c_s0    <= r_b_s0;
        r_d_value <= sum[FRAC_BITS+31:FRAC_BITS] + r_c_s0;
    end

    assign o_valid = r_d_valid;
    assign o_value = r_d_value;

    `SCL_ASSERT_IMP(a_latency, i_clk, i_rst_n, $past(i_rst_n, 4), r_d_valid == $past(o_pop && i_item.is_eval, 4), "result strobe out of step with evaluate items")

endmodule

FILE: src/sampled_curve_lerp.sv
// ---------------------------------------------------------------------------
// sampled_curve_lerp
// linear interpolation over a uniformly sampled curve held in a table
// ---------------------------------------------------------------------------
// usage
//   an item is taken on a rising edge with start high and busy low
//   cmd write stores sample_value at sample_index and gives no result
//   cmd evaluate gives one value, interpolated between two table samples
//   an evaluate item with sample count zero gives no result
//   min_x, scale and sample_count are set through the write port while idle
// timing
//   one item per cycle; the value sits on o_value with o_valid for one cycle
//   once it has passed two front stages, the queue, then table read, difference,
//   split multiply and final add in the back part
//   the receiver cannot stall, so the queue never fills and busy stays low
// reset
//   clears the configuration, the pipeline valids and the queue
//   table contents are undefined until written; there is no clearing pass
// ---------------------------------------------------------------------------
module sampled_curve_lerp #(
    parameter int SAMPLES   = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [9:0]  i_sample_index,
    input  logic [31:0] i_sample_value,
    input  logic [31:0] i_x,
    output logic        o_valid,
    output logic [31:0] o_value,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import scl_pkg::*;

    logic [31:0] r_min_x;
    logic [31:0] r_scale;
    logic [10:0] r_sample_count;
    logic [10:0] count_eff;

    logic       accept;
    logic       push;
    logic       pop;
    logic       hold;
    t_item      front_item;
    t_item      head_item;
    t_fifo_stat fifo_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x        <= '0;
            r_scale        <= '0;
            r_sample_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_X:        r_min_x        <= i_cfg_data;
                CFG_SCALE:        r_scale        <= i_cfg_data;
                CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    assign count_eff = (32'(r_sample_count) > 32'(SAMPLES)) ? 11'(SAMPLES) : r_sample_count;
    assign accept    = start && !busy;
    assign hold      = fifo_stat.full && !pop;

    scl_front #(
        .SAMPLES (SAMPLES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_cmd          (i_cmd),
        .i_sample_index (i_sample_index),
        .i_sample_value (i_sample_value),
        .i_x            (i_x),
        .i_min_x        (r_min_x),
        .i_scale        (r_scale),
        .i_count        (count_eff),
        .i_hold         (hold),
        .o_busy         (busy),
        .o_push         (push),
        .o_item         (front_item)
    );

    scl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_stat  (fifo_stat)
    );

    scl_back #(
        .SAMPLES   (SAMPLES),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (head_item),
        .i_stat  (fifo_stat),
        .i_count (count_eff),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_value (o_value)
    );

endmodule

FILE: tb/sampled_curve_lerp_check.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// curve_lerp_monitor
// watches the item, result and register ports of the curve interpolator,
// keeps its own copy of the sample table and registers, predicts each
// interpolated value and compares it with what the block returns
// ---------------------------------------------------------------------------
module curve_lerp_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_cmd,
    input  logic [9:0]  i_sample_index,
    input  logic [31:0] i_sample_value,
    input  logic [31:0] i_x,
    input  logic        i_valid,
    input  logic [31:0] i_value,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    import scl_pkg::*;

    localparam int CURVE_DEPTH = 1024;
    localparam int FRAC_W      = 16;

    logic [31:0] curve_table [CURVE_DEPTH];
    logic [31:0] min_x_q;
    logic [31:0] scale_q;
    logic [10:0] count_q;
    logic [31:0] value_q [$];
    int          fails   = 0;
    int          checked = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic logic [63:0] live_count();
        return (count_q > CURVE_DEPTH) ? 64'(CURVE_DEPTH) : 64'(count_q);
    endfunction

    function automatic logic [31:0] lerp_at(logic [31:0] xv);
        longint      d;
        logic        neg;
        logic [63:0] mag, tmag, t, lower, upper, frac, s0, s1, diff, prod, last;
        d    = longint'($signed(xv)) - longint'($signed(min_x_q));
        neg  = d < 0;
        mag  = neg ? 64'(-d) : 64'(d);
        tmag = (mag * {32'd0, scale_q}) >> FRAC_W;
        t    = neg ? -tmag : tmag;
        last = live_count() - 1;
        lower = neg ? 64'd0 : (tmag >> FRAC_W);
        if (lower > last) begin
            lower = last;
        end
        upper = lower + 1;
        if (upper > last) begin
            upper = last;
        end
        // below the curve start the first segment is extended
        frac = t - (lower << FRAC_W);
        s0   = {{32{curve_table[lower][31]}}, curve_table[lower]};
        s1   = {{32{curve_table[upper][31]}}, curve_table[upper]};
        diff = s1 - s0;
        prod = (diff * frac) >> FRAC_W;
        return s0[31:0] + prod[31:0];
    endfunction

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            min_x_q = '0;
            scale_q = '0;
            count_q = '0;
            value_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_X:        min_x_q = i_cfg_data;
                    CFG_SCALE:        scale_q = i_cfg_data;
                    CFG_SAMPLE_COUNT: count_q = i_cfg_data[10:0];
                    default:          ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (i_cmd == CMD_WRITE) begin
                    curve_table[i_sample_index] = i_sample_value;
                end else if (live_count() != 0) begin
                    value_q.push_back(lerp_at(i_x));
                end
            end
            if (i_valid) begin
                if (value_q.size() == 0) begin
                    fails++;
                    $display("%0t: value %h arrived with nothing outstanding", $time, i_value);
                end else begin
                    want = value_q.pop_front();
                    checked++;
                    if (want !== i_value) begin
                        fails++;
                        $display("%0t: value mismatch, expected %h actual %h",
                                 $time, want, i_value);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= value_q.size();
        o_checked    <= checked;
    end

endmodule

FILE: tb/sampled_curve_lerp_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sampled_curve_lerp_tb
// drives sample writes and curve evaluations into the interpolator under a
// series of curve settings, with random gaps between items; the monitor
// beside the block predicts every value and this top gives the verdict
// ---------------------------------------------------------------------------
module sampled_curve_lerp_tb;
    import scl_pkg::*;

    localparam int N_ITEMS     = 1650;
    localparam int TABLE_DEPTH = 1024;
    localparam int LAT_WAIT    = 12;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic        i_cmd          = CMD_WRITE;
    logic [9:0]  i_sample_index = '0;
    logic [31:0] i_sample_value = '0;
    logic [31:0] i_x            = '0;
    logic        i_cfg_we       = 1'b0;
    logic [1:0]  i_cfg_index    = CFG_MIN_X;
    logic [31:0] i_cfg_data     = '0;
    logic        busy;
    logic        o_valid;
    logic [31:0] o_value;

    int          fail_cnt;
    int          pending_cnt;
    int          checked_cnt;

    bit          loaded [TABLE_DEPTH];
    bit          idle_en   = 1'b1;
    int          item_cnt  = 0;
    int          eval_cnt  = 0;
    int          phase_cnt = 0;
    logic [31:0] cur_min_x = '0;
    int          span      = 1;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    sampled_curve_lerp dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_sample_index (i_sample_index),
        .i_sample_value (i_sample_value),
        .i_x            (i_x),
        .o_valid        (o_valid),
        .o_value        (o_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    curve_lerp_monitor u_mon (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cmd          (i_cmd),
        .i_sample_index (i_sample_index),
        .i_sample_value (i_sample_value),
        .i_x            (i_x),
        .i_valid        (o_valid),
        .i_value        (o_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_cnt),
        .o_pending      (pending_cnt),
        .o_checked      (checked_cnt)
    );

    // called on a rising edge, returns on the edge that takes the item
    task automatic push_item(logic c, logic [9:0] si, logic [31:0] sv, logic [31:0] xv);
        int gap;
        gap = (idle_en && $urandom_range(0, 99) < 9) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_cmd          <= c;
        i_sample_index <= si;
        i_sample_value <= sv;
        i_x            <= xv;
        do @(posedge i_clk); while (busy);
        item_cnt++;
        if (c == CMD_WRITE) begin
            loaded[si] = 1'b1;
        end else begin
            eval_cnt++;
        end
    endtask

    task automatic write_sample(logic [9:0] si, logic [31:0] sv);
        push_item(CMD_WRITE, si, sv, $urandom());
    endtask

    task automatic eval_at(logic [31:0] xv);
        push_item(CMD_EVAL, 10'($urandom()), $urandom(), xv);
    endtask

    // let every outstanding value come back and the pipeline empty
    task automatic settle();
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (LAT_WAIT) @(posedge i_clk);
    endtask

    task automatic set_curve(logic [31:0] mx, logic [31:0] sc, logic [31:0] cnt);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MIN_X;
        i_cfg_data  <= mx;
        @(posedge i_clk);
        i_cfg_index <= CFG_SCALE;
        i_cfg_data  <= sc;
        @(posedge i_clk);
        i_cfg_index <= CFG_SAMPLE_COUNT;
        i_cfg_data  <= cnt;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_min_x = mx;
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] near_x();
        int m;
        m = $urandom_range(0, 99);
        if (m < 60) begin
            return cur_min_x + 32'(int'($urandom_range(0, span + span / 4)) - span / 16);
        end else if (m < 80) begin
            return $urandom();
        end else if (m < 85) begin
            return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        end
        return cur_min_x + 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
    endfunction

    // never evaluate over a slot that has not been loaded
    task automatic fill_to(int eff);
        for (int i = 0; i < eff; i++) begin
            if (!loaded[i]) begin
                write_sample(10'(i), pick_sample());
            end
        end
    endtask

    initial begin
        #2_000_000;
        $display("[sampled_curve_lerp] ERROR");
        $finish;
    end

    initial begin
        int          cnt;
        int          eff;
        int          n;
        int          r;
        int          rnd_start;
        logic [31:0] mx;
        logic [31:0] sc;
        logic [63:0] s64;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty curve after reset, no values expected
        eval_at(32'h0000_0000);
        eval_at(32'h8000_0000);
        write_sample(10'd0, 32'h7FFF_FFFF);
        write_sample(10'd1, 32'h8000_0000);
        write_sample(10'd2, 32'h0000_0000);
        write_sample(10'd3, $urandom());
        write_sample(10'd1023, 32'hFFFF_FFFF);
        settle();

        set_curve(32'h0000_0000, 32'h0001_0000, 4);
        eval_at(32'h0000_0000);
        eval_at(32'h0001_8000);
        eval_at(32'h0002_8000);
        eval_at(32'h7FFF_FFFF);
        eval_at(32'h8000_0000);
        eval_at(32'hFFFF_0000);
        settle();

        // single sample, widest span and largest scale
        set_curve(32'h8000_0000, 32'hFFFF_FFFF, 1);
        eval_at(32'h7FFF_FFFF);
        eval_at(32'h8000_0000);
        settle();

        // zero scale always lands on the first sample
        set_curve(32'h7FFF_FFFF, 32'h0000_0000, 4);
        eval_at(32'h8000_0000);
        eval_at($urandom());
        settle();

        rnd_start = item_cnt;
        while (item_cnt - rnd_start < N_ITEMS || phase_cnt < 4) begin
            phase_cnt++;
            idle_en = (phase_cnt < 2 || phase_cnt > 3);
            if (phase_cnt == 2) begin
                cnt = 1024;
            end else if (phase_cnt == 4) begin
                cnt = 2047;
            end else begin
                case ($urandom_range(0, 9))
                    0:       cnt = 0;
                    1:       cnt = 1;
                    7:       cnt = $urandom_range(17, 64);
                    8, 9:    cnt = $urandom_range(65, 300);
                    default: cnt = $urandom_range(2, 16);
                endcase
            end
            eff = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;

            case ($urandom_range(0, 7))
                0:       mx = 32'h8000_0000;
                1:       mx = 32'h7FFF_FFFF;
                2, 3:    mx = $urandom();
                default: mx = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            endcase

            r = $urandom_range(1, 32'h00FF_0000);
            case ($urandom_range(0, 9))
                0:       sc = 32'h0000_0000;
                1:       sc = 32'hFFFF_FFFF;
                2, 3:    sc = $urandom();
                default: begin
                    if (eff > 1) begin
                        s64 = (64'(eff - 1) << 32) / 64'(r);
                        sc  = (s64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s64[31:0];
                    end else begin
                        sc = $urandom();
                    end
                end
            endcase

            set_curve(mx, sc, cnt);
            span = r;
            fill_to(eff);
            n = $urandom_range(40, 160);
            repeat (n) begin
                if ($urandom_range(0, 99) < 80) begin
                    eval_at(near_x());
                end else if (eff > 0 && $urandom_range(0, 3) != 0) begin
                    write_sample(10'($urandom_range(0, eff - 1)), pick_sample());
                end else begin
                    write_sample(10'($urandom()), pick_sample());
                end
            end
            settle();
        end

        $display("run covered %0d items, %0d of them evaluations, over %0d random curve settings",
                 item_cnt, eval_cnt, phase_cnt);
        $display("%0d interpolated values compared with the prediction", checked_cnt);
        if (fail_cnt == 0) begin
            $display("[sampled_curve_lerp] OK");
        end else begin
            $display("[sampled_curve_lerp] ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/scl_pkg.sv
src/scl_front.sv
src/scl_fifo.sv
src/scl_back.sv
src/sampled_curve_lerp.sv
tb/sampled_curve_lerp_check.sv
tb/sampled_curve_lerp_tb.sv
